/* hw/rtl/partial_reliability_stop_and_wait_sender_top_macros.svh */
// Assertion macros shared by the sender RTL
`ifndef PARTIAL_RELIABILITY_STOP_AND_WAIT_SENDER_TOP_MACROS_SVH
`define PARTIAL_RELIABILITY_STOP_AND_WAIT_SENDER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under reset
`define PRSW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under reset
`define PRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRSW_ASSERT_IMPL(lbl, ante, cons, msg)
`define PRSW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/prsw_pkg.sv */
// Package with types and constants for the stop-and-wait sender
package prsw_pkg;

    localparam int WINDOW_MAX_DEF = 8;

    localparam int SEQ_W    = 32;
    localparam int KIND_W   = 2;
    localparam int ACTION_W = 3;
    localparam int LOSS_W   = 4;
    localparam int CFG_W    = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_TRANSMIT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RETRANSMIT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELIVERED  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ABANDONED  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_IGNORED    = 3'd4;

    // Register select is byte address bit 2
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_MAX_LOSSES    = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 4'd5;
    localparam logic [CFG_W-1:0] MAX_LOSSES_RST    = 4'd3;

    typedef struct packed {
        logic [CFG_W-1:0] window_length;
        logic [CFG_W-1:0] max_losses;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    sequence_number;
        logic [LOSS_W-1:0]   loss_count;
    } result_t;

    typedef struct packed {
        logic             pending;
        logic [SEQ_W-1:0] next_sequence;
    } status_t;

endpackage

/* hw/rtl/prsw_event_if.sv */
// Event channel: send request, ack or timeout
interface prsw_event_if;
    logic                              valid;
    logic                              ready;
    logic [prsw_pkg::KIND_W-1:0]       kind;
    logic [prsw_pkg::SEQ_W-1:0]        ack_number;

    modport source (output valid, output kind, output ack_number, input ready);
    modport sink (input valid, input kind, input ack_number, output ready);
endinterface

/* hw/rtl/prsw_result_if.sv */
// Result channel: action, sequence number and window loss count
interface prsw_result_if;
    logic                              valid;
    logic                              ready;
    logic [prsw_pkg::ACTION_W-1:0]     action;
    logic [prsw_pkg::SEQ_W-1:0]        sequence_number;
    logic [prsw_pkg::LOSS_W-1:0]       loss_count;

    modport source (output valid, output action, output sequence_number,
                    output loss_count, input ready);
    modport sink (input valid, input action, input sequence_number,
                  input loss_count, output ready);
endinterface

/* hw/rtl/prsw_cfg.sv */
// APB configuration registers for the sender
module prsw_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prsw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [prsw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [prsw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output prsw_pkg::cfg_t                      cfg
);

    logic [prsw_pkg::CFG_W-1:0] window_length_reg;
    logic [prsw_pkg::CFG_W-1:0] max_losses_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= prsw_pkg::WINDOW_LENGTH_RST;
            max_losses_reg    <= prsw_pkg::MAX_LOSSES_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                prsw_pkg::REG_WINDOW_LENGTH:
                begin
                    window_length_reg <= pwdata[prsw_pkg::CFG_W-1:0];
                end
                prsw_pkg::REG_MAX_LOSSES:
                begin
                    max_losses_reg <= pwdata[prsw_pkg::CFG_W-1:0];
                end
                default:
                begin
                    max_losses_reg <= max_losses_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            prsw_pkg::REG_WINDOW_LENGTH:
            begin
                prdata = prsw_pkg::APB_DATA_W'(window_length_reg);
            end
            prsw_pkg::REG_MAX_LOSSES:
            begin
                prdata = prsw_pkg::APB_DATA_W'(max_losses_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.window_length = window_length_reg;
    assign cfg.max_losses    = max_losses_reg;

endmodule

/* hw/rtl/prsw_engine.sv */
// Sender state and per-event decision logic with loss window
module prsw_engine #(
    parameter int WINDOW_MAX = prsw_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [prsw_pkg::KIND_W-1:0]     kind,
    input  logic [prsw_pkg::SEQ_W-1:0]      ack_number,
    input  prsw_pkg::cfg_t                  cfg,
    output prsw_pkg::result_t               result,
    output prsw_pkg::status_t               status
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (LW > prsw_pkg::CFG_W) ? LW : prsw_pkg::CFG_W;

    logic [prsw_pkg::SEQ_W-1:0] seq_reg;
    logic [prsw_pkg::SEQ_W-1:0] seq_next;
    logic                       pending_reg;
    logic                       pending_next;
    logic [WINDOW_MAX-1:0]      hist_reg;
    logic [WINDOW_MAX-1:0]      hist_next;
    logic [PW-1:0]              pos_reg;
    logic [PW-1:0]              pos_next;

    logic [CW-1:0]              wl_ext;
    logic [CW-1:0]              eff_len;
    logic [PW-1:0]              pos_fix;
    logic [CW-1:0]              pos_inc;
    logic [PW-1:0]              pos_adv;
    logic [WINDOW_MAX-1:0]      hist_wr;
    logic                       record;
    logic                       ok_bit;
    logic [LW-1:0]              losses;
    logic [CW-1:0]              losses_ext;
    logic                       ack_match;
    logic [prsw_pkg::ACTION_W-1:0] action;

    // Effective window: window_length clamped to 1..WINDOW_MAX
    always_comb
    begin
        wl_ext = CW'(cfg.window_length);
        if (wl_ext == '0)
        begin
            eff_len = CW'(1);
        end
        else if (wl_ext > CW'(WINDOW_MAX))
        begin
            eff_len = CW'(WINDOW_MAX);
        end
        else
        begin
            eff_len = wl_ext;
        end
    end

    // Wrap a stale position before the write, then advance modulo the window
    always_comb
    begin
        pos_fix = (CW'(pos_reg) >= eff_len) ? '0 : pos_reg;
        pos_inc = CW'(pos_fix) + CW'(1);
        pos_adv = (pos_inc >= eff_len) ? '0 : pos_inc[PW-1:0];
    end

    assign ack_match = (ack_number == prsw_pkg::SEQ_W'(seq_reg + 32'd1));

    // Which attempt gets recorded, independent of the abandon test
    always_comb
    begin
        record = 1'b0;
        ok_bit = 1'b0;
        unique case (kind)
            prsw_pkg::KIND_ACK:
            begin
                record = pending_reg;
                ok_bit = ack_match;
            end
            prsw_pkg::KIND_TIMEOUT:
            begin
                record = pending_reg;
            end
            default:
            begin
                record = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        hist_wr          = hist_reg;
        hist_wr[pos_fix] = ok_bit;
        hist_next        = record ? hist_wr : hist_reg;
    end

    always_comb
    begin
        losses = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if ((CW'(i) < eff_len) && !hist_next[i])
            begin
                losses = LW'(losses + LW'(1));
            end
        end
        losses_ext = CW'(losses);
    end

    always_comb
    begin
        action       = prsw_pkg::ACT_IGNORED;
        seq_next     = seq_reg;
        pending_next = pending_reg;
        unique case (kind)
            prsw_pkg::KIND_SEND:
            begin
                if (!pending_reg)
                begin
                    pending_next = 1'b1;
                    action       = prsw_pkg::ACT_TRANSMIT;
                end
            end
            prsw_pkg::KIND_ACK:
            begin
                if (pending_reg)
                begin
                    if (ack_match)
                    begin
                        seq_next     = prsw_pkg::SEQ_W'(seq_reg + 32'd1);
                        pending_next = 1'b0;
                        action       = prsw_pkg::ACT_DELIVERED;
                    end
                    else
                    begin
                        action = prsw_pkg::ACT_RETRANSMIT;
                    end
                end
            end
            prsw_pkg::KIND_TIMEOUT:
            begin
                if (pending_reg)
                begin
                    if (losses_ext > CW'(cfg.max_losses))
                    begin
                        pending_next = 1'b0;
                        action       = prsw_pkg::ACT_ABANDONED;
                    end
                    else
                    begin
                        action = prsw_pkg::ACT_RETRANSMIT;
                    end
                end
            end
            default:
            begin
                action = prsw_pkg::ACT_IGNORED;
            end
        endcase
    end

    assign pos_next = record ? pos_adv : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= '0;
            pending_reg <= 1'b0;
            hist_reg    <= '1;
            pos_reg     <= '0;
        end
        else if (step)
        begin
            seq_reg     <= seq_next;
            pending_reg <= pending_next;
            hist_reg    <= hist_next;
            pos_reg     <= pos_next;
        end
    end

    assign result.action          = action;
    assign result.sequence_number = seq_reg;
    assign result.loss_count      = (losses_ext > CW'(15)) ? prsw_pkg::LOSS_W'(15)
                                                           : losses_ext[prsw_pkg::LOSS_W-1:0];

    assign status.pending       = pending_reg;
    assign status.next_sequence = seq_reg;

endmodule

/* hw/rtl/partial_reliability_stop_and_wait_sender_top.sv */
// Top level of the partial-reliability stop-and-wait sender
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+--------------------------------------
//  evt      | in  | valid / ready   | kind, ack_number
//  result   | out | valid / ready   | action, sequence_number, loss_count
//  apb      | in  | psel / penable  | paddr, pwdata, prdata (pready = 1)
//
// One event per cycle sustained while the result side is ready; an accepted
// request passes through the input register, then the result register.
// The state updates when an event moves from the input register to the result
// register; a stalled result holds the request in the input register, and with
// both registers full the input stalls until the result side takes one.
// Reset clears sequence, pending flag and position, and marks every window
// entry ok; configuration resets to window_length 5, max_losses 3.
`include "partial_reliability_stop_and_wait_sender_top_macros.svh"

module partial_reliability_stop_and_wait_sender_top #(
    parameter int WINDOW_MAX = prsw_pkg::WINDOW_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    prsw_event_if.sink                          evt,
    prsw_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prsw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [prsw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [prsw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    prsw_pkg::cfg_t             cfg;
    prsw_pkg::result_t          eng_result;
    prsw_pkg::status_t          status;

    logic                       in_valid_reg;
    logic [prsw_pkg::KIND_W-1:0] in_kind_reg;
    logic [prsw_pkg::SEQ_W-1:0] in_ack_reg;
    logic                       out_valid_reg;
    prsw_pkg::result_t          out_res_reg;
    logic                       advance;

    prsw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prsw_engine #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .kind       (in_kind_reg),
        .ack_number (in_ack_reg),
        .cfg        (cfg),
        .result     (eng_result),
        .status     (status)
    );

    // Move the held request forward when the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_kind_reg <= evt.kind;
            in_ack_reg  <= evt.ack_number;
        end
        if (advance)
        begin
            out_res_reg <= eng_result;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.action          = out_res_reg.action;
    assign result.sequence_number = out_res_reg.sequence_number;
    assign result.loss_count      = out_res_reg.loss_count;

    `PRSW_ASSERT_IMPL(a_abandon_on_timeout,
        advance && (eng_result.action == prsw_pkg::ACT_ABANDONED),
        in_kind_reg == prsw_pkg::KIND_TIMEOUT, "abandon without timeout")
    `PRSW_ASSERT_NEXT(a_deliver_advances,
        advance && (eng_result.action == prsw_pkg::ACT_DELIVERED),
        status.next_sequence == prsw_pkg::SEQ_W'($past(status.next_sequence) + 32'd1),
        "delivery did not advance sequence")
    `PRSW_ASSERT_NEXT(a_done_clears_pending,
        advance && ((eng_result.action == prsw_pkg::ACT_DELIVERED) ||
                    (eng_result.action == prsw_pkg::ACT_ABANDONED)),
        !status.pending, "pending not cleared")
    `PRSW_ASSERT_NEXT(a_held_request_kept, in_valid_reg && !advance,
        in_valid_reg && $stable(in_kind_reg), "held request lost")

endmodule

/* verif/prsw_sender_checker.sv */
// Checker that predicts and compares every result of the stop-and-wait sender
`timescale 1ns / 1ps

module prsw_sender_checker
    import prsw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    prsw_event_if                 evt,
    prsw_result_if                result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    error_count,
    output int                    events_seen,
    output int                    results_seen,
    output logic [SEQ_W-1:0]      seq_hint
);

    logic [CFG_W-1:0]          window_cfg;
    logic [CFG_W-1:0]          loss_limit;
    logic [SEQ_W-1:0]          next_seq;
    logic                      pending;
    logic [WINDOW_MAX_DEF-1:0] ack_ok;
    int                        slot;
    result_t                   expected_q[$];
    int                        fails;
    int                        n_events;
    int                        n_results;

    // Window length 0 acts as 1; anything above the ring size is clamped
    function automatic int window_span();
        if (window_cfg == '0)
            return 1;
        if (window_cfg > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return int'(window_cfg);
    endfunction

    function automatic int losses_in_window();
        int span;
        int n;
        span = window_span();
        n = 0;
        for (int i = 0; i < span; i++)
        begin
            if (!ack_ok[i])
                n++;
        end
        return n;
    endfunction

    function automatic void log_attempt(bit ok);
        int span;
        span = window_span();
        // wrap first in case the window shrank under the current slot
        if (slot >= span)
            slot = 0;
        ack_ok[slot] = ok;
        slot++;
        if (slot >= span)
            slot = 0;
    endfunction

    function automatic result_t step_sender(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack);
        result_t r;
        r.action = ACT_IGNORED;
        r.sequence_number = next_seq;
        case (kind)
            KIND_SEND:
            begin
                if (!pending)
                begin
                    pending = 1'b1;
                    r.action = ACT_TRANSMIT;
                end
            end
            KIND_ACK:
            begin
                if (pending)
                begin
                    if (ack == next_seq + 32'd1)
                    begin
                        log_attempt(1'b1);
                        next_seq = next_seq + 32'd1;
                        pending = 1'b0;
                        r.action = ACT_DELIVERED;
                    end
                    else
                    begin
                        log_attempt(1'b0);
                        r.action = ACT_RETRANSMIT;
                    end
                end
            end
            KIND_TIMEOUT:
            begin
                if (pending)
                begin
                    log_attempt(1'b0);
                    if (losses_in_window() > int'(loss_limit))
                    begin
                        pending = 1'b0;
                        r.action = ACT_ABANDONED;
                    end
                    else
                        r.action = ACT_RETRANSMIT;
                end
            end
            default: ;
        endcase
        r.loss_count = LOSS_W'(losses_in_window());
        return r;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            window_cfg = WINDOW_LENGTH_RST;
            loss_limit = MAX_LOSSES_RST;
            next_seq = '0;
            pending = 1'b0;
            ack_ok = '1;
            slot = 0;
            expected_q.delete();
            fails = 0;
            n_events = 0;
            n_results = 0;
            error_count <= 0;
            events_seen <= 0;
            results_seen <= 0;
            seq_hint <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WINDOW_LENGTH)
                    window_cfg = pwdata[CFG_W-1:0];
                else if (paddr[2] == REG_MAX_LOSSES)
                    loss_limit = pwdata[CFG_W-1:0];
            end
            if (evt.valid && evt.ready)
            begin
                expected_q.push_back(step_sender(evt.kind, evt.ack_number));
                n_events++;
            end
            if (result.valid && result.ready)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result expected none actual %0h/%0h/%0h",
                             $time, result.action, result.sequence_number,
                             result.loss_count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("action", want.action, result.action);
                    check_field("sequence_number", want.sequence_number,
                                result.sequence_number);
                    check_field("loss_count", want.loss_count, result.loss_count);
                end
            end
            error_count <= fails;
            events_seen <= n_events;
            results_seen <= n_results;
            seq_hint <= next_seq;
        end
    end

endmodule

/* verif/partial_reliability_stop_and_wait_sender_top_tb.sv */
// Stimulus, flow control and verdict for the stop-and-wait sender
`timescale 1ns / 1ps

module partial_reliability_stop_and_wait_sender_top_tb;
    import prsw_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 18;
    localparam int NOISE_PCT     = 15;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 56;
    localparam int HOLD_PHASE    = 2;
    localparam int STEADY_PHASE  = 4;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int               n_sent;
    bit               no_idle;
    bit               hold_req;
    int               error_count;
    int               events_seen;
    int               results_seen;
    logic [SEQ_W-1:0] seq_hint;

    // window length and loss limit per phase: extremes, zero and saturating values
    logic [CFG_W-1:0] window_set [PHASES] = '{4'd5, 4'd1, 4'd8, 4'd0, 4'd15,
                                              4'd2, 4'd8, 4'd3, 4'd4};
    logic [CFG_W-1:0] limit_set  [PHASES] = '{4'd3, 4'd0, 4'd8, 4'd0, 4'd15,
                                              4'd1, 4'd0, 4'd15, 4'd2};

    prsw_event_if  evt();
    prsw_result_if result();

    partial_reliability_stop_and_wait_sender_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    prsw_sender_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .error_count  (error_count),
        .events_seen  (events_seen),
        .results_seen (results_seen),
        .seq_hint     (seq_hint)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Result side: random stalls, or a long hold-off on request
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((evt.valid && evt.ready) || (result.valid && result.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("partial_reliability_stop_and_wait_sender_top_tb: errors");
        $finish;
    end

    // Offer one request; an ack meant to match waits until the checker has
    // seen every earlier request so the sequence number is current
    task automatic push_event(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] ack,
                              input bit to_current);
        logic [SEQ_W-1:0] value;
        value = ack;
        if (to_current || (!no_idle && $urandom_range(99, 0) < IDLE_PCT))
        begin
            evt.valid <= 1'b0;
            @(posedge clk);
            while ((to_current && events_seen != n_sent) ||
                   (!no_idle && $urandom_range(99, 0) < IDLE_PCT))
                @(posedge clk);
        end
        if (to_current)
            value = seq_hint + 32'd1;
        evt.valid <= 1'b1;
        evt.kind <= kind;
        evt.ack_number <= value;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic settle();
        evt.valid <= 1'b0;
        while (results_seen != n_sent)
            @(posedge clk);
    endtask

    // Two back-to-back APB writes; psel stays high between them
    task automatic write_regs(input logic [CFG_W-1:0] window_len,
                              input logic [CFG_W-1:0] loss_lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata <= APB_DATA_W'(window_len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        paddr <= {REG_MAX_LOSSES, 2'b00};
        pwdata <= APB_DATA_W'(loss_lim);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int  stop;
        int  misses;
        bit  hold_done;
        rst_n = 1'b0;
        evt.valid <= 1'b0;
        evt.kind <= KIND_SEND;
        evt.ack_number <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        n_sent = 0;
        hold_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // nothing pending: all ignored
        push_event(KIND_ACK, 32'd1, 1'b0);
        push_event(KIND_TIMEOUT, 32'hFFFF_FFFF, 1'b0);
        push_event(KIND_UNUSED, 32'hFFFF_FFFF, 1'b0);
        // send, then repeats and junk while pending
        push_event(KIND_SEND, 32'h0, 1'b0);
        push_event(KIND_SEND, 32'h0, 1'b0);
        push_event(KIND_UNUSED, 32'h0, 1'b0);
        push_event(KIND_ACK, 32'hFFFF_FFFF, 1'b0);
        push_event(KIND_ACK, 32'h0, 1'b0);
        push_event(KIND_TIMEOUT, 32'h0, 1'b0);
        push_event(KIND_ACK, '0, 1'b1);
        // run the window up until the message is abandoned
        push_event(KIND_SEND, 32'h0, 1'b0);
        push_event(KIND_TIMEOUT, 32'h0, 1'b0);
        push_event(KIND_TIMEOUT, 32'h0, 1'b0);
        push_event(KIND_TIMEOUT, 32'h0, 1'b0);
        push_event(KIND_TIMEOUT, 32'h0, 1'b0);
        push_event(KIND_ACK, '0, 1'b1);
        push_event(KIND_SEND, 32'h0, 1'b0);
        push_event(KIND_ACK, 32'hAAAA_AAAA, 1'b0);
        push_event(KIND_ACK, 32'h5555_5555, 1'b0);
        push_event(KIND_ACK, '0, 1'b1);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_regs(window_set[phase], limit_set[phase]);
            no_idle = (phase == STEADY_PHASE);
            stop = n_sent + PHASE_ITEMS;
            while (n_sent < stop)
            begin
                if (phase == HOLD_PHASE && !hold_done && n_sent + PHASE_ITEMS / 2 >= stop)
                begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(99, 0) < NOISE_PCT)
                    push_event(KIND_W'($urandom_range(3, 0)), $urandom, 1'b0);
                else
                begin
                    // one message: send, a few losses, usually the right ack
                    misses = $urandom_range(5, 0);
                    push_event(KIND_SEND, $urandom, 1'b0);
                    repeat (misses)
                    begin
                        case ($urandom_range(3, 0))
                            0, 1: push_event(KIND_TIMEOUT, $urandom, 1'b0);
                            2: push_event(KIND_ACK, $urandom, 1'b0);
                            default: push_event(KIND_ACK,
                                seq_hint + ($urandom_range(1, 0) ? 32'd2 : 32'd0), 1'b0);
                        endcase
                    end
                    if ($urandom_range(9, 0) != 0)
                        push_event(KIND_ACK, '0, 1'b1);
                end
            end
            settle();
            no_idle = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("partial_reliability_stop_and_wait_sender_top_tb: clean");
        else
            $display("partial_reliability_stop_and_wait_sender_top_tb: errors");
        $finish;
    end

endmodule
